/* src/xyz_to_azimuth_elevation_unit_assert.svh */
// Assertion macros for the xyz to azimuth/elevation unit.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef XYZ_TO_AZIMUTH_ELEVATION_UNIT_ASSERT_SVH
`define XYZ_TO_AZIMUTH_ELEVATION_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define XYZAE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons after ante, delayed by dly.
`define XYZAE_ASSERT_AFTER(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

/* src/xyzae_pkg.sv */
// Shared types, constants and helpers for the xyz to azimuth/elevation unit.
// Depends on nothing; used by every module of the unit.
package xyzae_pkg;

  localparam int VEC_W      = 36;
  localparam int ANG_W      = 30;
  localparam int GUARD_BITS = 8;
  localparam int TABLE_LEN  = 24;
  localparam int GAIN_SHIFT = 24;
  localparam int Q16_W      = 26;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [Q16_W-1:0] q16_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [24:0] azimuth;
    logic signed [23:0] elevation;
  } out_t;

  localparam logic [23:0] GAIN_Q24      = 24'd10188014;
  localparam ang_t        HALF_TURN_Q20 = 30'sd188743680;
  localparam q16_t        AZ_LIMIT      = 26'sd11796480;
  localparam q16_t        EL_LIMIT      = 26'sd5898240;

  localparam ang_t ATAN_DEG_Q20 [TABLE_LEN] = '{
    30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
    30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
    30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
    30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
    30'sd917,      30'sd458,      30'sd229,      30'sd115,
    30'sd57,       30'sd29,       30'sd14,       30'sd7
  };

  // Q.20 degrees to Q.16 with round, then clamp to +-lim.
  function automatic q16_t to_q16_sat(input ang_t a, input q16_t lim);
    logic signed [ANG_W:0]   s;
    logic signed [Q16_W:0]   q;
    logic signed [Q16_W:0]   lim_w;
    q16_t                    r;
    s     = {a[ANG_W-1], a} + 31'sd8;
    q     = (Q16_W+1)'(s >>> 4);
    lim_w = {lim[Q16_W-1], lim};
    if (q > lim_w) begin
      r = lim;
    end else if (q < -lim_w) begin
      r = -lim;
    end else begin
      r = q[Q16_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/xyzae_cordic_stage.sv */
// One registered CORDIC vectoring iteration with a pass-through sideband.
// Depends on xyzae_pkg for the vector/angle types and the arctangent table.
module xyzae_cordic_stage #(
  parameter int SHIFT = 0,
  parameter int SW    = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  xyzae_pkg::vec_t   in_x,
  input  xyzae_pkg::vec_t   in_y,
  input  xyzae_pkg::ang_t   in_ang,
  input  logic [SW-1:0]     in_sb,
  output logic              out_valid,
  output xyzae_pkg::vec_t   out_x,
  output xyzae_pkg::vec_t   out_y,
  output xyzae_pkg::ang_t   out_ang,
  output logic [SW-1:0]     out_sb
);

  logic            valid_r;
  xyzae_pkg::vec_t x_r, x_nxt, y_r, y_nxt, xs, ys;
  xyzae_pkg::ang_t ang_r, ang_nxt;
  logic [SW-1:0]   sb_r;

  always_comb begin
    xs = in_x >>> SHIFT;
    ys = in_y >>> SHIFT;
    if (!in_y[xyzae_pkg::VEC_W-1]) begin
      x_nxt   = in_x + ys;
      y_nxt   = in_y - xs;
      ang_nxt = in_ang + xyzae_pkg::ATAN_DEG_Q20[SHIFT];
    end else begin
      x_nxt   = in_x - ys;
      y_nxt   = in_y + xs;
      ang_nxt = in_ang - xyzae_pkg::ATAN_DEG_Q20[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    ang_r <= ang_nxt;
    sb_r  <= in_sb;
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_ang   = ang_r;
  assign out_sb    = sb_r;

endmodule

/* src/xyzae_gain.sv */
// Two-stage CORDIC gain correction: split multiply by K, then sum, round and shift.
// Depends on xyzae_pkg for the vector type and the gain constant.
module xyzae_gain #(
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  xyzae_pkg::vec_t in_mag,
  input  logic [SW-1:0]   in_sb,
  output logic            out_valid,
  output xyzae_pkg::vec_t out_mag,
  output logic [SW-1:0]   out_sb
);

  localparam int LO_W  = 18;
  localparam int HI_W  = xyzae_pkg::VEC_W - 1 - LO_W;
  localparam int PLO_W = LO_W + 24;
  localparam int PHI_W = HI_W + 24;
  localparam int SUM_W = PHI_W + LO_W + 1;
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (xyzae_pkg::GAIN_SHIFT - 1);

  logic               a_valid_r, b_valid_r;
  logic [PLO_W-1:0]   p_lo_r, p_lo_nxt;
  logic [PHI_W-1:0]   p_hi_r, p_hi_nxt;
  logic [SW-1:0]      a_sb_r, b_sb_r;
  logic [SUM_W-1:0]   sum;
  xyzae_pkg::vec_t    mag_r, mag_nxt;

  always_comb begin
    p_lo_nxt = PLO_W'(in_mag[LO_W-1:0]) * PLO_W'(xyzae_pkg::GAIN_Q24);
    p_hi_nxt = PHI_W'(in_mag[xyzae_pkg::VEC_W-2:LO_W]) * PHI_W'(xyzae_pkg::GAIN_Q24);
    sum      = {1'b0, p_hi_r, {LO_W{1'b0}}} + SUM_W'(p_lo_r) + ROUND_HALF;
    mag_nxt  = xyzae_pkg::VEC_W'(sum[SUM_W-1:xyzae_pkg::GAIN_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p_lo_r <= p_lo_nxt;
    p_hi_r <= p_hi_nxt;
    a_sb_r <= in_sb;
    mag_r  <= mag_nxt;
    b_sb_r <= a_sb_r;
  end

  assign out_valid = b_valid_r;
  assign out_mag   = mag_r;
  assign out_sb    = b_sb_r;

endmodule

/* src/xyz_to_azimuth_elevation_unit.sv */
// Top level of the xyz to azimuth/elevation unit: input prep, two CORDIC passes, output.
// Depends on xyzae_pkg, xyzae_cordic_stage, xyzae_gain and the assertion header.
//
// Usage:
//   Drive in_data (pos_x forward, pos_y right, pos_z down) and raise start for one
//   cycle per vector; a transfer happens at every edge with start high and busy low.
//   busy is always low, so a new vector may enter in every cycle.
//   Each vector gives one result on out_data, azimuth in Q8.16 and elevation in Q7.16
//   degrees, marked by a one-cycle out_valid strobe.
//   The path runs through one input register, CORDIC_STAGES azimuth iterations,
//   two gain-multiply stages, CORDIC_STAGES elevation iterations and one output
//   register.
//   Throughput is one vector per cycle; every iteration is its own register stage.
//   Stage counts above 24 use the 24 table entries.
//   Reset clears every valid bit, so no strobe follows reset until a new transfer.
//   The receiver cannot stall; results are shown once and not held.
`include "xyz_to_azimuth_elevation_unit_assert.svh"

module xyz_to_azimuth_elevation_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  xyzae_pkg::in_t    in_data,
  output logic              out_valid,
  output xyzae_pkg::out_t   out_data
);

  localparam int NS  = (CORDIC_STAGES > xyzae_pkg::TABLE_LEN) ?
                       xyzae_pkg::TABLE_LEN : CORDIC_STAGES;
  localparam int LAT = 2 * NS + 4;
  localparam int SW1 = 25;
  localparam int SWG = 49;
  localparam int SW2 = 26;

  // input prep
  logic            s0_valid_r;
  xyzae_pkg::vec_t s0_x_r, s0_y_r, s0_x_nxt, s0_y_nxt, x_ext, y_ext;
  xyzae_pkg::ang_t s0_ang_r, s0_ang_nxt;
  logic [SW1-1:0]  s0_sb_r, s0_sb_nxt;

  always_comb begin
    x_ext = {{(xyzae_pkg::VEC_W-24-xyzae_pkg::GUARD_BITS){in_data.pos_x[23]}},
             in_data.pos_x, {xyzae_pkg::GUARD_BITS{1'b0}}};
    y_ext = {{(xyzae_pkg::VEC_W-24-xyzae_pkg::GUARD_BITS){in_data.pos_y[23]}},
             in_data.pos_y, {xyzae_pkg::GUARD_BITS{1'b0}}};
    if (in_data.pos_x[23]) begin
      s0_x_nxt   = -x_ext;
      s0_y_nxt   = -y_ext;
      s0_ang_nxt = in_data.pos_y[23] ? -xyzae_pkg::HALF_TURN_Q20 : xyzae_pkg::HALF_TURN_Q20;
    end else begin
      s0_x_nxt   = x_ext;
      s0_y_nxt   = y_ext;
      s0_ang_nxt = '0;
    end
    s0_sb_nxt = {(in_data.pos_x == 24'sd0) && (in_data.pos_y == 24'sd0), in_data.pos_z};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_x_r   <= s0_x_nxt;
    s0_y_r   <= s0_y_nxt;
    s0_ang_r <= s0_ang_nxt;
    s0_sb_r  <= s0_sb_nxt;
  end

  // azimuth pass
  logic            p1_valid [0:NS];
  xyzae_pkg::vec_t p1_x     [0:NS];
  xyzae_pkg::vec_t p1_y     [0:NS];
  xyzae_pkg::ang_t p1_ang   [0:NS];
  logic [SW1-1:0]  p1_sb    [0:NS];

  assign p1_valid[0] = s0_valid_r;
  assign p1_x[0]     = s0_x_r;
  assign p1_y[0]     = s0_y_r;
  assign p1_ang[0]   = s0_ang_r;
  assign p1_sb[0]    = s0_sb_r;

  for (genvar i = 0; i < NS; i++) begin : g_az
    xyzae_cordic_stage #(.SHIFT(i), .SW(SW1)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (p1_valid[i]),
      .in_x      (p1_x[i]),
      .in_y      (p1_y[i]),
      .in_ang    (p1_ang[i]),
      .in_sb     (p1_sb[i]),
      .out_valid (p1_valid[i+1]),
      .out_x     (p1_x[i+1]),
      .out_y     (p1_y[i+1]),
      .out_ang   (p1_ang[i+1]),
      .out_sb    (p1_sb[i+1])
    );
  end

  // gain correction
  logic            zero1;
  xyzae_pkg::vec_t g_mag_in, g_mag;
  xyzae_pkg::ang_t az_ang;
  xyzae_pkg::q16_t az_q16;
  logic [SWG-1:0]  g_sb_in, g_sb;
  logic            g_valid;

  always_comb begin
    zero1    = p1_sb[NS][24];
    g_mag_in = zero1 ? '0 : p1_x[NS];
    az_ang   = zero1 ? '0 : p1_ang[NS];
    az_q16   = xyzae_pkg::to_q16_sat(az_ang, xyzae_pkg::AZ_LIMIT);
    g_sb_in  = {p1_sb[NS][23:0], az_q16[24:0]};
  end

  xyzae_gain #(.SW(SWG)) u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p1_valid[NS]),
    .in_mag    (g_mag_in),
    .in_sb     (g_sb_in),
    .out_valid (g_valid),
    .out_mag   (g_mag),
    .out_sb    (g_sb)
  );

  // elevation pass
  logic            p2_valid [0:NS];
  xyzae_pkg::vec_t p2_x     [0:NS];
  xyzae_pkg::vec_t p2_y     [0:NS];
  xyzae_pkg::ang_t p2_ang   [0:NS];
  logic [SW2-1:0]  p2_sb    [0:NS];
  logic signed [23:0] g_z;
  xyzae_pkg::vec_t z_ext;

  always_comb begin
    g_z   = g_sb[SWG-1:25];
    z_ext = {{(xyzae_pkg::VEC_W-24-xyzae_pkg::GUARD_BITS){g_z[23]}},
             g_z, {xyzae_pkg::GUARD_BITS{1'b0}}};
  end

  assign p2_valid[0] = g_valid;
  assign p2_x[0]     = g_mag;
  assign p2_y[0]     = -z_ext;
  assign p2_ang[0]   = '0;
  assign p2_sb[0]    = {(g_mag == '0) && (g_z == 24'sd0), g_sb[24:0]};

  for (genvar i = 0; i < NS; i++) begin : g_el
    xyzae_cordic_stage #(.SHIFT(i), .SW(SW2)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (p2_valid[i]),
      .in_x      (p2_x[i]),
      .in_y      (p2_y[i]),
      .in_ang    (p2_ang[i]),
      .in_sb     (p2_sb[i]),
      .out_valid (p2_valid[i+1]),
      .out_x     (p2_x[i+1]),
      .out_y     (p2_y[i+1]),
      .out_ang   (p2_ang[i+1]),
      .out_sb    (p2_sb[i+1])
    );
  end

  // output register
  logic            out_valid_r;
  xyzae_pkg::out_t out_data_r, out_data_nxt;
  xyzae_pkg::ang_t el_ang;
  xyzae_pkg::q16_t el_q16;

  always_comb begin
    el_ang                 = p2_sb[NS][25] ? '0 : p2_ang[NS];
    el_q16                 = xyzae_pkg::to_q16_sat(el_ang, xyzae_pkg::EL_LIMIT);
    out_data_nxt.azimuth   = p2_sb[NS][24:0];
    out_data_nxt.elevation = el_q16[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p2_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic az_ok, el_ok, az_zero, xy_zero;

  always_comb begin
    az_ok   = (out_data.azimuth <= 25'sd11796480) && (out_data.azimuth >= -25'sd11796480);
    el_ok   = (out_data.elevation <= 24'sd5898240) && (out_data.elevation >= -24'sd5898240);
    az_zero = (out_data.azimuth == 25'sd0);
    xy_zero = (in_data.pos_x == 24'sd0) && (in_data.pos_y == 24'sd0);
  end

  `XYZAE_ASSERT_AFTER(a_latency, start && !busy, LAT, out_valid, "result strobe missing")
  `XYZAE_ASSERT_NOW(a_no_orphan, out_valid, $past(start, LAT), "result without a transfer")
  `XYZAE_ASSERT_NOW(a_range, out_valid, az_ok && el_ok, "angle out of range")
  `XYZAE_ASSERT_AFTER(a_zero_vec, start && xy_zero, LAT, az_zero, "zero vector azimuth not zero")

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for xyz_to_azimuth_elevation_unit: sends position vectors,
// predicts azimuth and elevation with a bit-exact two-pass CORDIC model, checks each result.
// Depends on xyzae_pkg for the payload types and on the unit's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CLK_PERIOD      = 2;
  localparam int     CORDIC_ITERS    = 16;
  localparam int     TABLE_ENTRIES   = 24;
  localparam int     LATENCY         = 2 * CORDIC_ITERS + 4;
  localparam int     DRAIN_LIMIT     = 8 * LATENCY;
  localparam longint CORDIC_GAIN_Q24 = 64'sd10188014;
  localparam longint HALF_TURN_Q20   = 64'sd180 <<< 20;
  localparam longint AZ_MAX_Q16      = 64'sd11796480;
  localparam longint EL_MAX_Q16      = 64'sd5898240;
  localparam int     POS_MAX         = 8388607;
  localparam int     POS_MIN         = -8388608;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  xyzae_pkg::in_t    in_data;
  logic              out_valid;
  xyzae_pkg::out_t   out_data;

  xyzae_pkg::out_t   pending_angles[$];
  xyzae_pkg::out_t   want;
  int                fail_count = 0;
  int                sent_count = 0;
  int                checked_count = 0;
  bit                pauses_on = 1'b1;

  longint atan_deg_q20 [0:TABLE_ENTRIES-1] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  xyz_to_azimuth_elevation_unit #(
    .CORDIC_STAGES(CORDIC_ITERS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint vector_angle(input longint x0, input longint y0,
                                          output longint mag);
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint ang;
    int     iters;
    int     i;
    x = x0;
    y = y0;
    ang = 0;
    iters = (CORDIC_ITERS > TABLE_ENTRIES) ? TABLE_ENTRIES : CORDIC_ITERS;
    for (i = 0; i < iters; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + atan_deg_q20[i];
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - atan_deg_q20[i];
      end
    end
    mag = x;
    return ang;
  endfunction

  function automatic longint q20_to_q16_clamped(input longint a, input longint lim);
    longint r;
    r = (a + 8) >>> 4;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic xyzae_pkg::out_t convert_xyz(input xyzae_pkg::in_t v);
    longint x;
    longint y;
    longint z;
    longint az;
    longint el;
    longint mag;
    longint range_h;
    longint base;
    longint unused_mag;
    xyzae_pkg::out_t res;
    x = v.pos_x;
    y = v.pos_y;
    z = v.pos_z;
    x = x * 256;
    y = y * 256;
    z = z * 256;
    az = 0;
    el = 0;
    range_h = 0;
    if (x != 0 || y != 0) begin
      base = 0;
      if (x < 0) begin
        base = (y >= 0) ? HALF_TURN_Q20 : -HALF_TURN_Q20;
        x = -x;
        y = -y;
      end
      az = base + vector_angle(x, y, mag);
      range_h = (mag * CORDIC_GAIN_Q24 + (64'sd1 <<< 23)) >>> 24;
    end
    if (range_h != 0 || z != 0) begin
      el = vector_angle(range_h, -z, unused_mag);
    end
    res.azimuth   = 25'(q20_to_q16_clamped(az, AZ_MAX_Q16));
    res.elevation = 24'(q20_to_q16_clamped(el, EL_MAX_Q16));
    return res;
  endfunction

  function automatic int rand_field(input int bits);
    int s;
    s = int'($urandom) >>> (32 - bits);
    return s;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected result azimuth %0d elevation %0d", $time,
                 out_data.azimuth, out_data.elevation);
        fail_count++;
      end else begin
        want = pending_angles.pop_front();
        checked_count++;
        if (out_data.azimuth !== want.azimuth) begin
          $display("%0t: azimuth expected %0d actual %0d", $time,
                   want.azimuth, out_data.azimuth);
          fail_count++;
        end
        if (out_data.elevation !== want.elevation) begin
          $display("%0t: elevation expected %0d actual %0d", $time,
                   want.elevation, out_data.elevation);
          fail_count++;
        end
      end
    end
  end

  task automatic send_xyz(input int x, input int y, input int z);
    xyzae_pkg::in_t v;
    v.pos_x = x[23:0];
    v.pos_y = y[23:0];
    v.pos_z = z[23:0];
    start <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_angles.push_back(convert_xyz(v));
    sent_count++;
  endtask

  task automatic maybe_pause();
    if (pauses_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_angles.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_angles.size() != 0) begin
      $display("%0t: %0d results expected but never seen", $time, pending_angles.size());
      fail_count++;
      pending_angles.delete();
    end
  endtask

  task automatic test_directed();
    send_xyz(0, 0, 0);
    send_xyz(0, 0, POS_MAX);
    send_xyz(0, 0, POS_MIN);
    send_xyz(0, 0, 1);
    send_xyz(0, 0, -1);
    send_xyz(POS_MAX, 0, 0);
    send_xyz(POS_MIN, 0, 0);
    send_xyz(0, POS_MAX, 0);
    send_xyz(0, POS_MIN, 0);
    send_xyz(1, 0, 0);
    send_xyz(-1, 0, 0);
    send_xyz(0, 1, 0);
    send_xyz(0, -1, 0);
    send_xyz(POS_MIN, 1, 0);
    send_xyz(POS_MIN, -1, 0);
    send_xyz(-5, 7, 3);
    send_xyz(-5, -7, -3);
    send_xyz(POS_MAX, POS_MAX, POS_MAX);
    send_xyz(POS_MIN, POS_MIN, POS_MIN);
    send_xyz(POS_MAX, POS_MIN, POS_MIN);
    send_xyz(POS_MIN, POS_MAX, POS_MAX);
    send_xyz(-1, -1, -1);
    send_xyz(1, 1, POS_MIN);
    wait_all_results();
  endtask

  task automatic test_full_range(input int n);
    repeat (n) begin
      send_xyz(rand_field(24), rand_field(24), rand_field(24));
      maybe_pause();
    end
  endtask

  task automatic test_small_vectors(input int n);
    repeat (n) begin
      send_xyz(int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4,
               int'($urandom_range(0, 8)) - 4);
      maybe_pause();
    end
  endtask

  task automatic test_axes_and_diagonals(input int n);
    int a;
    int b;
    int c;
    repeat (n) begin
      a = rand_field($urandom_range(1, 24));
      b = rand_field($urandom_range(1, 24));
      c = rand_field($urandom_range(1, 24));
      case ($urandom_range(0, 5))
        0: send_xyz(a, 0, c);
        1: send_xyz(0, b, c);
        2: send_xyz(0, 0, c);
        3: send_xyz(a, ($urandom_range(0, 1) != 0) ? a : -a, c);
        4: send_xyz(-(a == POS_MIN ? POS_MAX : (a < 0 ? -a : a)) - 1, 0, c);
        default: send_xyz(a, b, 0);
      endcase
      maybe_pause();
    end
  endtask

  task automatic test_back_to_back(input int n);
    pauses_on = 1'b0;
    repeat (n) begin
      send_xyz(rand_field($urandom_range(1, 24)), rand_field($urandom_range(1, 24)),
               rand_field($urandom_range(1, 24)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_range(700);
    wait_all_results();
    test_small_vectors(300);
    test_axes_and_diagonals(400);
    wait_all_results();
    test_back_to_back(530);
    wait_all_results();
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d vectors, checked %0d results: axes, extremes, zero vectors,", sent_count,
             checked_count);
    $display("half-plane wrap, small and full-range values, with and without input gaps.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
